// File: rtl/mpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MessagePack event decoder.
// No dependencies.
package mpd_pkg;

    localparam int NestDepthDef = 16;
    localparam int MaxEvents    = 20;

    typedef enum logic [4:0] {
        EV_DOC_START = 5'd0,
        EV_DOC_END   = 5'd1,
        EV_NIL       = 5'd2,
        EV_FALSE     = 5'd3,
        EV_TRUE      = 5'd4,
        EV_UINT      = 5'd5,
        EV_INT       = 5'd6,
        EV_F32       = 5'd7,
        EV_F64       = 5'd8,
        EV_STR       = 5'd9,
        EV_BIN       = 5'd10,
        EV_PAYLOAD   = 5'd11,
        EV_KEY       = 5'd12,
        EV_ARR_START = 5'd13,
        EV_ARR_END   = 5'd14,
        EV_MAP_START = 5'd15,
        EV_MAP_END   = 5'd16,
        EV_ARR_SEP   = 5'd17,
        EV_MAP_SEP   = 5'd18,
        EV_ERROR     = 5'd19
    } t_ev;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TRUNC   = 3'd1,
        ERR_ILLEGAL = 3'd2,
        ERR_BAD_KEY = 3'd3,
        ERR_EXT     = 3'd4,
        ERR_DEPTH   = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_IDLE, PH_VALUE, PH_KEY, PH_HEADER, PH_PAYLOAD, PH_KEYPAYLOAD
    } t_phase;

    typedef enum logic [3:0] {
        PK_NONE, PK_UINT, PK_INT, PK_F32, PK_F64, PK_STR, PK_BIN, PK_ARR, PK_MAP, PK_KEY
    } t_pk;

    typedef enum logic [2:0] {
        A_SCALAR, A_OPEN, A_TEXT, A_HDR, A_SHIFT, A_PAYLOAD, A_FAIL
    } t_act_kind;

    typedef enum logic [3:0] {
        ST_WAIT, ST_START, ST_DISPATCH, ST_EMPTYEND, ST_VDONE, ST_POP,
        ST_FAIL1, ST_FAIL2, ST_EOS, ST_EOSERR, ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DOCSTART, OP_EXEC, OP_EMPTYEND, OP_VDONE, OP_POP,
        OP_FAIL1, OP_FAIL2, OP_RESET, OP_FLUSH
    } t_op;

    typedef struct packed {
        t_ev         kind;
        logic [63:0] value;
        logic [31:0] len;
        logic [4:0]  nest;
        t_err        err;
    } t_event;

    typedef struct packed {
        t_act_kind   kind;
        t_ev         ev;
        logic [63:0] value;
        logic [31:0] len;
        logic        is_map;
        logic        is_key;
        t_pk         pk;
        logic [1:0]  slog;
        t_err        code;
    } t_act;

    typedef struct packed {
        t_op  op;
        t_err code;
    } t_cmd;

    typedef struct packed {
        t_act   act;
        t_phase phase;
        logic   present;
        logic   eos;
        logic   discard;
        logic   hbl_le1;
        logic   pay_last;
        logic   vd_pop;
        logic   vd_again;
        logic   can_emit;
        logic   hold_v;
    } t_stat;

endpackage

// File: rtl/mpd_in_if.sv
`timescale 1ns / 1ps
// Input byte channel: valid/ready plus one stream byte and its flags.
// No dependencies.
interface mpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       byte_present;

    modport source (output valid, data_byte, end_of_stream, byte_present, input ready);
    modport sink   (input valid, data_byte, end_of_stream, byte_present, output ready);
endinterface

// File: rtl/mpd_out_if.sv
`timescale 1ns / 1ps
// Output event channel: valid/ready plus one decoded event.
// No dependencies.
interface mpd_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  event_kind;
    logic [63:0] event_value;
    logic [31:0] event_length;
    logic [4:0]  nest_level;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (output valid, event_kind, event_value, event_length, nest_level,
                    error_code, last_of_run, input ready);
    modport sink   (input valid, event_kind, event_value, event_length, nest_level,
                    error_code, last_of_run, output ready);
endinterface

// File: rtl/messagepack_event_decoder.sv
`timescale 1ns / 1ps
// Top level of the MessagePack event decoder: controller, datapath, channels.
// Depends on mpd_pkg, mpd_in_if, mpd_out_if, mpd_ctrl, mpd_datapath.
//
//  channel | dir | carries
//  i_in    | in  | data_byte, end_of_stream, byte_present
//  o_ev    | out | event_kind, event_value, event_length, nest_level,
//          |     | error_code, last_of_run
//
// Each byte passes through load, start (doc start issued here), decode (twice on
// the last header byte), empty container end, element close, end-of-stream check
// and release as needed before the next byte is taken. Each closed container adds
// a close and a parent frame read from the stack RAM; an error adds error and doc
// end events, truncation one more step. Events go via a one-entry hold register and
// an output register; the controller stalls while both are full. Reset is
// synchronous and clears all control state; the stack RAM needs no clearing.
module messagepack_event_decoder #(
    parameter int NEST_DEPTH = mpd_pkg::NestDepthDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mpd_in_if.sink    i_in,
    mpd_out_if.source o_ev
);
    mpd_pkg::t_cmd   w_cmd;
    mpd_pkg::t_stat  w_stat;
    mpd_pkg::t_event w_event;
    logic            w_last;
    logic            w_valid;

    mpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    mpd_datapath #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_stream (i_in.end_of_stream),
        .i_byte_present  (i_in.byte_present),
        .i_out_ready     (o_ev.ready),
        .o_stat          (w_stat),
        .o_event         (w_event),
        .o_last          (w_last),
        .o_valid         (w_valid)
    );

    assign o_ev.valid        = w_valid;
    assign o_ev.event_kind   = w_event.kind;
    assign o_ev.event_value  = w_event.value;
    assign o_ev.event_length = w_event.len;
    assign o_ev.nest_level   = w_event.nest;
    assign o_ev.error_code   = w_event.err;
    assign o_ev.last_of_run  = w_last;

`ifndef SYNTHESIS
    // a new item is taken only after the previous run is fully released
    a_accept_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !w_stat.hold_v)
        else $error("input accepted with an event still held");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.valid && o_ev.event_kind == mpd_pkg::EV_ERROR)
        |-> (o_ev.error_code != mpd_pkg::ERR_NONE))
        else $error("error event without a code");

    a_length_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.valid && o_ev.event_length != '0)
        |-> (o_ev.event_kind == mpd_pkg::EV_STR || o_ev.event_kind == mpd_pkg::EV_BIN
             || o_ev.event_kind == mpd_pkg::EV_KEY
             || o_ev.event_kind == mpd_pkg::EV_ARR_START
             || o_ev.event_kind == mpd_pkg::EV_ARR_END
             || o_ev.event_kind == mpd_pkg::EV_MAP_START
             || o_ev.event_kind == mpd_pkg::EV_MAP_END))
        else $error("length on an event kind that carries none");
`endif
endmodule

// File: rtl/mpd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpd_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/mpd_datapath.sv
`timescale 1ns / 1ps
// Decoder datapath: byte decode, header accumulator, container stack, event buffers.
// Depends on mpd_pkg and mpd_ram.
module mpd_datapath #(
    parameter int NEST_DEPTH = mpd_pkg::NestDepthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpd_pkg::t_cmd  i_cmd,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_stream,
    input  logic           i_byte_present,
    input  logic           i_out_ready,
    output mpd_pkg::t_stat o_stat,
    output mpd_pkg::t_event o_event,
    output logic           o_last,
    output logic           o_valid
);
    localparam int SpW = $clog2(NEST_DEPTH + 1);
    localparam int AW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int FrW = 65;

    // MessagePack format codes
    localparam logic [7:0] FMT_NIL    = 8'hc0;
    localparam logic [7:0] FMT_FALSE  = 8'hc2;
    localparam logic [7:0] FMT_TRUE   = 8'hc3;
    localparam logic [7:0] FMT_BIN8   = 8'hc4;
    localparam logic [7:0] FMT_BIN16  = 8'hc5;
    localparam logic [7:0] FMT_BIN32  = 8'hc6;
    localparam logic [7:0] FMT_EXT8   = 8'hc7;
    localparam logic [7:0] FMT_EXT16  = 8'hc8;
    localparam logic [7:0] FMT_EXT32  = 8'hc9;
    localparam logic [7:0] FMT_F32    = 8'hca;
    localparam logic [7:0] FMT_F64    = 8'hcb;
    localparam logic [7:0] FMT_UINT8  = 8'hcc;
    localparam logic [7:0] FMT_UINT64 = 8'hcf;
    localparam logic [7:0] FMT_INT8   = 8'hd0;
    localparam logic [7:0] FMT_INT64  = 8'hd3;
    localparam logic [7:0] FMT_FEXT1  = 8'hd4;
    localparam logic [7:0] FMT_FEXT16 = 8'hd8;
    localparam logic [7:0] FMT_STR8   = 8'hd9;
    localparam logic [7:0] FMT_STR16  = 8'hda;
    localparam logic [7:0] FMT_STR32  = 8'hdb;
    localparam logic [7:0] FMT_ARR16  = 8'hdc;
    localparam logic [7:0] FMT_ARR32  = 8'hdd;
    localparam logic [7:0] FMT_MAP16  = 8'hde;
    localparam logic [7:0] FMT_MAP32  = 8'hdf;

    logic [7:0]          r_byte;
    logic                r_eos;
    logic                r_present;
    mpd_pkg::t_phase     r_phase;
    mpd_pkg::t_pk        r_pk;
    logic [1:0]          r_slog;
    logic [3:0]          r_hbl;
    logic [63:0]         r_acc;
    logic [31:0]         r_pay_left;
    logic [SpW-1:0]      r_sp;
    logic                r_discard;
    logic [31:0]         r_top_total;
    logic [31:0]         r_top_left;
    logic                r_top_map;
    mpd_pkg::t_event     r_hold;
    logic                r_hold_v;
    mpd_pkg::t_event     r_out;
    logic                r_out_last;
    logic                r_out_v;
    logic [4:0]          r_ev_cnt;

    mpd_pkg::t_act   act;
    mpd_pkg::t_event ev_new;
    logic            do_emit;
    logic            ev_ok;
    logic            flush;
    logic            out_free;
    logic            sp_full;
    logic [31:0]     left_dec;
    logic [63:0]     sext;
    logic            push;
    logic [FrW-1:0]  ram_rdata;
    logic [4:0]      nest_cur;
    logic [4:0]      nest_inc;

    assign sp_full  = r_sp >= SpW'(NEST_DEPTH);
    assign left_dec = r_top_left - {31'd0, (r_top_left != '0)};
    assign nest_cur = 5'(r_sp);
    assign nest_inc = 5'(r_sp + SpW'(1));
    assign out_free = !r_out_v || i_out_ready;

    always_comb begin
        case (r_slog)
            2'd0:    sext = {{56{r_acc[7]}}, r_acc[7:0]};
            2'd1:    sext = {{48{r_acc[15]}}, r_acc[15:0]};
            2'd2:    sext = {{32{r_acc[31]}}, r_acc[31:0]};
            default: sext = r_acc;
        endcase
    end

    // what the current byte (or finished header) asks for
    always_comb begin
        act = '{kind: mpd_pkg::A_FAIL, ev: mpd_pkg::EV_NIL, value: '0, len: '0,
                is_map: 1'b0, is_key: 1'b0, pk: mpd_pkg::PK_NONE, slog: 2'd0,
                code: mpd_pkg::ERR_ILLEGAL};
        case (r_phase)
            mpd_pkg::PH_IDLE, mpd_pkg::PH_VALUE: begin
                case (r_byte) inside
                    [8'h00:8'h7f]: begin
                        act.kind = mpd_pkg::A_SCALAR;
                        act.ev = mpd_pkg::EV_UINT;
                        act.value = {56'd0, r_byte};
                    end
                    [8'h80:8'h8f]: begin
                        act.kind = mpd_pkg::A_OPEN;
                        act.is_map = 1'b1;
                        act.len = {28'd0, r_byte[3:0]};
                    end
                    [8'h90:8'h9f]: begin
                        act.kind = mpd_pkg::A_OPEN;
                        act.len = {28'd0, r_byte[3:0]};
                    end
                    [8'ha0:8'hbf]: begin
                        act.kind = mpd_pkg::A_TEXT;
                        act.ev = mpd_pkg::EV_STR;
                        act.len = {27'd0, r_byte[4:0]};
                    end
                    [8'he0:8'hff]: begin
                        act.kind = mpd_pkg::A_SCALAR;
                        act.ev = mpd_pkg::EV_INT;
                        act.value = {{56{1'b1}}, r_byte};
                    end
                    FMT_NIL: begin
                        act.kind = mpd_pkg::A_SCALAR;
                        act.ev = mpd_pkg::EV_NIL;
                    end
                    FMT_FALSE: begin
                        act.kind = mpd_pkg::A_SCALAR;
                        act.ev = mpd_pkg::EV_FALSE;
                    end
                    FMT_TRUE: begin
                        act.kind = mpd_pkg::A_SCALAR;
                        act.ev = mpd_pkg::EV_TRUE;
                    end
                    [FMT_BIN8:FMT_BIN32]: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_BIN;
                        act.slog = r_byte[1:0];
                    end
                    FMT_F32, FMT_F64: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = r_byte[0] ? mpd_pkg::PK_F64 : mpd_pkg::PK_F32;
                        act.slog = r_byte[1:0];
                    end
                    [FMT_UINT8:FMT_UINT64]: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_UINT;
                        act.slog = r_byte[1:0];
                    end
                    [FMT_INT8:FMT_INT64]: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_INT;
                        act.slog = r_byte[1:0];
                    end
                    [FMT_STR8:FMT_STR32]: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_STR;
                        act.slog = 2'(r_byte[1:0] - 2'd1);
                    end
                    FMT_ARR16, FMT_ARR32: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_ARR;
                        act.slog = 2'(r_byte[1:0] + 2'd1);
                    end
                    FMT_MAP16, FMT_MAP32: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_MAP;
                        act.slog = 2'(r_byte[1:0] - 2'd1);
                    end
                    [FMT_EXT8:FMT_EXT32], [FMT_FEXT1:FMT_FEXT16]: begin
                        act.code = mpd_pkg::ERR_EXT;
                    end
                    default: act.code = mpd_pkg::ERR_ILLEGAL;
                endcase
            end
            mpd_pkg::PH_KEY: begin
                case (r_byte) inside
                    [8'ha0:8'hbf]: begin
                        act.kind = mpd_pkg::A_TEXT;
                        act.ev = mpd_pkg::EV_KEY;
                        act.is_key = 1'b1;
                        act.len = {27'd0, r_byte[4:0]};
                    end
                    FMT_STR8: begin
                        act.kind = mpd_pkg::A_HDR;
                        act.pk = mpd_pkg::PK_KEY;
                    end
                    default: act.code = mpd_pkg::ERR_BAD_KEY;
                endcase
            end
            mpd_pkg::PH_HEADER: begin
                if (r_hbl != '0) begin
                    act.kind = mpd_pkg::A_SHIFT;
                end else begin
                    act.len = r_acc[31:0];
                    case (r_pk)
                        mpd_pkg::PK_UINT: begin
                            act.kind = mpd_pkg::A_SCALAR;
                            act.ev = mpd_pkg::EV_UINT;
                            act.value = r_acc;
                            act.len = '0;
                        end
                        mpd_pkg::PK_INT: begin
                            act.kind = mpd_pkg::A_SCALAR;
                            act.ev = mpd_pkg::EV_INT;
                            act.value = sext;
                            act.len = '0;
                        end
                        mpd_pkg::PK_F32, mpd_pkg::PK_F64: begin
                            act.kind = mpd_pkg::A_SCALAR;
                            act.ev = (r_pk == mpd_pkg::PK_F32) ? mpd_pkg::EV_F32
                                                                : mpd_pkg::EV_F64;
                            act.value = r_acc;
                            act.len = '0;
                        end
                        mpd_pkg::PK_STR: begin
                            act.kind = mpd_pkg::A_TEXT;
                            act.ev = mpd_pkg::EV_STR;
                        end
                        mpd_pkg::PK_BIN: begin
                            act.kind = mpd_pkg::A_TEXT;
                            act.ev = mpd_pkg::EV_BIN;
                        end
                        mpd_pkg::PK_KEY: begin
                            act.kind = mpd_pkg::A_TEXT;
                            act.ev = mpd_pkg::EV_KEY;
                            act.is_key = 1'b1;
                        end
                        mpd_pkg::PK_ARR, mpd_pkg::PK_MAP: begin
                            act.kind = mpd_pkg::A_OPEN;
                            act.is_map = (r_pk == mpd_pkg::PK_MAP);
                        end
                        default: act.code = mpd_pkg::ERR_ILLEGAL;
                    endcase
                end
            end
            mpd_pkg::PH_PAYLOAD, mpd_pkg::PH_KEYPAYLOAD: act.kind = mpd_pkg::A_PAYLOAD;
            default: act.code = mpd_pkg::ERR_ILLEGAL;
        endcase
        if (act.kind == mpd_pkg::A_OPEN && sp_full) begin
            act.kind = mpd_pkg::A_FAIL;
            act.code = mpd_pkg::ERR_DEPTH;
        end
    end

    // event produced by the current command
    always_comb begin
        do_emit = 1'b0;
        ev_new = '{kind: mpd_pkg::EV_DOC_START, value: '0, len: '0, nest: '0,
                   err: mpd_pkg::ERR_NONE};
        case (i_cmd.op)
            mpd_pkg::OP_DOCSTART: do_emit = 1'b1;
            mpd_pkg::OP_EXEC: begin
                case (act.kind)
                    mpd_pkg::A_SCALAR: begin
                        do_emit = 1'b1;
                        ev_new.kind = act.ev;
                        ev_new.value = act.value;
                        ev_new.nest = nest_cur;
                    end
                    mpd_pkg::A_OPEN: begin
                        do_emit = 1'b1;
                        ev_new.kind = act.is_map ? mpd_pkg::EV_MAP_START
                                                 : mpd_pkg::EV_ARR_START;
                        ev_new.len = act.len;
                        ev_new.nest = nest_inc;
                    end
                    mpd_pkg::A_TEXT: begin
                        do_emit = 1'b1;
                        ev_new.kind = act.ev;
                        ev_new.len = act.len;
                        ev_new.nest = nest_cur;
                    end
                    mpd_pkg::A_PAYLOAD: begin
                        do_emit = 1'b1;
                        ev_new.kind = mpd_pkg::EV_PAYLOAD;
                        ev_new.value = {56'd0, r_byte};
                        ev_new.nest = nest_cur;
                    end
                    default: do_emit = 1'b0;
                endcase
            end
            mpd_pkg::OP_EMPTYEND: begin
                do_emit = 1'b1;
                ev_new.kind = act.is_map ? mpd_pkg::EV_MAP_END : mpd_pkg::EV_ARR_END;
                ev_new.nest = nest_inc;
            end
            mpd_pkg::OP_VDONE: begin
                do_emit = 1'b1;
                if (r_sp == '0) begin
                    ev_new.kind = mpd_pkg::EV_DOC_END;
                end else if (left_dec != '0) begin
                    ev_new.kind = r_top_map ? mpd_pkg::EV_MAP_SEP : mpd_pkg::EV_ARR_SEP;
                    ev_new.nest = nest_cur;
                end else begin
                    ev_new.kind = r_top_map ? mpd_pkg::EV_MAP_END : mpd_pkg::EV_ARR_END;
                    ev_new.len = r_top_total;
                    ev_new.nest = nest_cur;
                end
            end
            mpd_pkg::OP_FAIL1: begin
                do_emit = 1'b1;
                ev_new.kind = mpd_pkg::EV_ERROR;
                ev_new.nest = nest_cur;
                ev_new.err = i_cmd.code;
            end
            mpd_pkg::OP_FAIL2: begin
                do_emit = 1'b1;
                ev_new.kind = mpd_pkg::EV_DOC_END;
            end
            default: do_emit = 1'b0;
        endcase
    end

    assign ev_ok = do_emit && (r_ev_cnt < 5'(mpd_pkg::MaxEvents));
    assign flush = (i_cmd.op == mpd_pkg::OP_FLUSH) && r_hold_v;
    assign push  = (i_cmd.op == mpd_pkg::OP_EXEC) && (act.kind == mpd_pkg::A_OPEN)
                   && (act.len != '0) && (r_sp != '0);

    // frames below the top one live in RAM; the top frame is held in registers
    mpd_ram #(
        .WIDTH (FrW),
        .DEPTH (NEST_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (AW'(r_sp - SpW'(1))),
        .i_wdata ({r_top_total, r_top_left, r_top_map}),
        .i_raddr (AW'(r_sp - SpW'(2))),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mpd_pkg::PH_IDLE;
            r_hbl      <= '0;
            r_pay_left <= '0;
            r_sp       <= '0;
            r_discard  <= 1'b0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_ev_cnt   <= '0;
        end else begin
            if (ev_ok) begin
                r_ev_cnt <= 5'(r_ev_cnt + 5'd1);
            end
            if ((ev_ok && r_hold_v) || flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (ev_ok) begin
                r_hold_v <= 1'b1;
            end else if (flush) begin
                r_hold_v <= 1'b0;
            end
            case (i_cmd.op)
                mpd_pkg::OP_LOAD: r_ev_cnt <= '0;
                mpd_pkg::OP_DOCSTART: r_phase <= mpd_pkg::PH_VALUE;
                mpd_pkg::OP_EXEC: begin
                    case (act.kind)
                        mpd_pkg::A_OPEN: begin
                            if (act.len != '0) begin
                                r_sp <= SpW'(r_sp + SpW'(1));
                                r_phase <= act.is_map ? mpd_pkg::PH_KEY : mpd_pkg::PH_VALUE;
                            end
                        end
                        mpd_pkg::A_TEXT: begin
                            r_pay_left <= act.len;
                            if (act.is_key) begin
                                r_phase <= (act.len == '0) ? mpd_pkg::PH_VALUE
                                                           : mpd_pkg::PH_KEYPAYLOAD;
                            end else if (act.len != '0) begin
                                r_phase <= mpd_pkg::PH_PAYLOAD;
                            end
                        end
                        mpd_pkg::A_HDR: begin
                            r_hbl <= 4'd1 << act.slog;
                            r_phase <= mpd_pkg::PH_HEADER;
                        end
                        mpd_pkg::A_SHIFT: r_hbl <= 4'(r_hbl - 4'd1);
                        mpd_pkg::A_PAYLOAD: begin
                            if (r_pay_left != '0) begin
                                r_pay_left <= 32'(r_pay_left - 32'd1);
                            end
                            if (r_pay_left <= 32'd1 && r_phase == mpd_pkg::PH_KEYPAYLOAD) begin
                                r_phase <= mpd_pkg::PH_VALUE;
                            end
                        end
                        default: r_phase <= r_phase;
                    endcase
                end
                mpd_pkg::OP_VDONE: begin
                    if (r_sp == '0) begin
                        r_phase <= mpd_pkg::PH_IDLE;
                        r_discard <= 1'b1;
                    end else if (left_dec != '0) begin
                        r_phase <= r_top_map ? mpd_pkg::PH_KEY : mpd_pkg::PH_VALUE;
                    end else begin
                        r_sp <= SpW'(r_sp - SpW'(1));
                    end
                end
                mpd_pkg::OP_FAIL2: begin
                    r_sp <= '0;
                    r_phase <= mpd_pkg::PH_IDLE;
                    r_hbl <= '0;
                    r_pay_left <= '0;
                    r_discard <= 1'b1;
                end
                mpd_pkg::OP_RESET: begin
                    r_sp <= '0;
                    r_phase <= mpd_pkg::PH_IDLE;
                    r_hbl <= '0;
                    r_pay_left <= '0;
                    r_discard <= 1'b0;
                end
                default: r_sp <= r_sp;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ev_ok) begin
            r_hold <= ev_new;
        end
        if ((ev_ok && r_hold_v) || flush) begin
            r_out <= r_hold;
            r_out_last <= flush;
        end
        case (i_cmd.op)
            mpd_pkg::OP_LOAD: begin
                r_byte <= i_data_byte;
                r_eos <= i_end_of_stream;
                r_present <= i_byte_present;
            end
            mpd_pkg::OP_EXEC: begin
                case (act.kind)
                    mpd_pkg::A_OPEN: begin
                        // an empty container never becomes the top frame
                        if (act.len != '0) begin
                            r_top_total <= act.len;
                            r_top_left <= act.len;
                            r_top_map <= act.is_map;
                        end
                    end
                    mpd_pkg::A_HDR: begin
                        r_pk <= act.pk;
                        r_slog <= act.slog;
                        r_acc <= '0;
                    end
                    mpd_pkg::A_SHIFT: r_acc <= {r_acc[55:0], r_byte};
                    default: r_acc <= r_acc;
                endcase
            end
            mpd_pkg::OP_VDONE: begin
                if (r_sp != '0) begin
                    r_top_left <= left_dec;
                end
            end
            mpd_pkg::OP_POP: begin
                {r_top_total, r_top_left, r_top_map} <= ram_rdata;
            end
            default: r_acc <= r_acc;
        endcase
    end

    always_comb begin
        o_stat.act      = act;
        o_stat.phase    = r_phase;
        o_stat.present  = r_present;
        o_stat.eos      = r_eos;
        o_stat.discard  = r_discard;
        o_stat.hbl_le1  = r_hbl <= 4'd1;
        o_stat.pay_last = r_pay_left <= 32'd1;
        o_stat.vd_pop   = (left_dec == '0) && (r_sp > SpW'(1));
        o_stat.vd_again = (left_dec == '0) && (r_sp == SpW'(1));
        o_stat.can_emit = !r_hold_v || out_free;
        o_stat.hold_v   = r_hold_v;
    end

    assign o_event = r_out;
    assign o_last  = r_out_last;
    assign o_valid = r_out_v;
endmodule

// File: rtl/mpd_ctrl.sv
`timescale 1ns / 1ps
// Decoder controller: sequences the steps of one input item over the datapath.
// Depends on mpd_pkg.
module mpd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mpd_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mpd_pkg::t_cmd  o_cmd
);
    mpd_pkg::t_state r_state, n_state;
    mpd_pkg::t_err   r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpd_pkg::ST_WAIT;
            r_code  <= mpd_pkg::ERR_NONE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_in_ready = 1'b0;
        o_cmd.op   = mpd_pkg::OP_NONE;
        o_cmd.code = r_code;
        case (r_state)
            mpd_pkg::ST_WAIT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = mpd_pkg::OP_LOAD;
                    n_state = mpd_pkg::ST_START;
                end
            end
            mpd_pkg::ST_START: begin
                if (i_stat.present && !i_stat.discard) begin
                    if (i_stat.phase != mpd_pkg::PH_IDLE) begin
                        n_state = mpd_pkg::ST_DISPATCH;
                    end else if (i_stat.can_emit) begin
                        o_cmd.op = mpd_pkg::OP_DOCSTART;
                        n_state = mpd_pkg::ST_DISPATCH;
                    end
                end else begin
                    n_state = mpd_pkg::ST_EOS;
                end
            end
            mpd_pkg::ST_DISPATCH: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_EXEC;
                    case (i_stat.act.kind)
                        mpd_pkg::A_SCALAR: n_state = mpd_pkg::ST_VDONE;
                        mpd_pkg::A_OPEN: n_state = (i_stat.act.len == '0)
                                                   ? mpd_pkg::ST_EMPTYEND : mpd_pkg::ST_EOS;
                        mpd_pkg::A_TEXT: n_state = (!i_stat.act.is_key && i_stat.act.len == '0)
                                                   ? mpd_pkg::ST_VDONE : mpd_pkg::ST_EOS;
                        // last header byte: decode the completed header next
                        mpd_pkg::A_SHIFT: n_state = i_stat.hbl_le1 ? mpd_pkg::ST_DISPATCH
                                                                   : mpd_pkg::ST_EOS;
                        mpd_pkg::A_PAYLOAD: n_state = (i_stat.pay_last &&
                                                       i_stat.phase == mpd_pkg::PH_PAYLOAD)
                                                      ? mpd_pkg::ST_VDONE : mpd_pkg::ST_EOS;
                        mpd_pkg::A_FAIL: begin
                            n_code = i_stat.act.code;
                            n_state = mpd_pkg::ST_FAIL1;
                        end
                        default: n_state = mpd_pkg::ST_EOS;
                    endcase
                end
            end
            mpd_pkg::ST_EMPTYEND: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_EMPTYEND;
                    n_state = mpd_pkg::ST_VDONE;
                end
            end
            mpd_pkg::ST_VDONE: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_VDONE;
                    if (i_stat.vd_pop) begin
                        n_state = mpd_pkg::ST_POP;
                    end else if (!i_stat.vd_again) begin
                        n_state = mpd_pkg::ST_EOS;
                    end
                end
            end
            mpd_pkg::ST_POP: begin
                o_cmd.op = mpd_pkg::OP_POP;
                n_state = mpd_pkg::ST_VDONE;
            end
            mpd_pkg::ST_FAIL1: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_FAIL1;
                    n_state = mpd_pkg::ST_FAIL2;
                end
            end
            mpd_pkg::ST_FAIL2: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_FAIL2;
                    n_state = mpd_pkg::ST_EOS;
                end
            end
            mpd_pkg::ST_EOS: begin
                if (!i_stat.eos) begin
                    n_state = mpd_pkg::ST_FIN;
                end else if (i_stat.discard) begin
                    o_cmd.op = mpd_pkg::OP_RESET;
                    n_state = mpd_pkg::ST_FIN;
                end else if (i_stat.phase != mpd_pkg::PH_IDLE) begin
                    n_state = mpd_pkg::ST_EOSERR;
                end else if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_DOCSTART;
                    n_state = mpd_pkg::ST_EOSERR;
                end
            end
            mpd_pkg::ST_EOSERR: begin
                n_code = mpd_pkg::ERR_TRUNC;
                n_state = mpd_pkg::ST_FAIL1;
            end
            mpd_pkg::ST_FIN: begin
                if (i_stat.can_emit) begin
                    o_cmd.op = mpd_pkg::OP_FLUSH;
                    n_state = mpd_pkg::ST_WAIT;
                end
            end
            default: n_state = mpd_pkg::ST_WAIT;
        endcase
    end
endmodule
